### hw/rtl/mbfi_pkg.sv
// Shared constants, types and the reciprocal table for the metaball field block.
package mbfi_pkg;
    localparam int BALL_LIMIT = 6;
    localparam int POS_REGS = 6;
    localparam int CELLS = (BALL_LIMIT < POS_REGS) ? BALL_LIMIT : POS_REGS;
    localparam int CNT_W = 3;
    localparam int COORD_W = 7;
    localparam int POS_W = 15;
    localparam int ROOT_W = 8;
    localparam int SQ_W = 16;
    localparam int STEP_W = 4;
    localparam int ROOT_STEPS = ROOT_W;
    localparam logic [7:0] FULL_SCALE = 8'd255;
    localparam logic [7:0] FLOOR_OFFSET = 8'd32;

    localparam logic [CNT_W-1:0] REG_BALL_COUNT = 3'd0;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_OUT  = 3'b100
    } state_t;

    // Hand-off between neighbouring cells.
    typedef struct packed {
        logic [COORD_W-1:0] px;
        logic [COORD_W-1:0] py;
        logic [7:0]         sum;
    } link_t;

    typedef logic [255:0][7:0] recip_tab_t;

    // Floor of 255 / d for d in 1..255 by repeated subtraction; d of zero gives full scale.
    function automatic recip_tab_t build_recip();
        recip_tab_t t;
        int r;
        int q;
        for (int k = 0; k < 256; k++)
        begin
            r = 255;
            q = 0;
            if (k == 0)
                q = 255;
            else
            begin
                while (r >= k)
                begin
                    r = r - k;
                    q = q + 1;
                end
            end
            t[k] = 8'(q);
        end
        return t;
    endfunction

    localparam recip_tab_t RECIP_TAB = build_recip();

    function automatic logic [7:0] recip(input logic [ROOT_W-1:0] d);
        return RECIP_TAB[d];
    endfunction
endpackage

### hw/rtl/mbfi_cell.sv
// One ball cell: bit-serial square root of the squared distance and saturating accumulate.
module mbfi_cell (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic                        active,
    input  logic [mbfi_pkg::POS_W-1:0]  position,
    input  mbfi_pkg::link_t             link_in,
    output mbfi_pkg::link_t             link_out
);
    localparam logic [mbfi_pkg::STEP_W-1:0] STEP_W_ONE = 4'd1;

    logic [mbfi_pkg::SQ_W-1:0]   rem_reg, rem_next;
    logic [mbfi_pkg::ROOT_W-1:0] root_reg, root_next;
    logic [mbfi_pkg::STEP_W-1:0] step_reg, step_next;
    mbfi_pkg::link_t             hold_reg, hold_next;
    logic [6:0] bx, by, dx, dy;
    logic [mbfi_pkg::SQ_W-1:0] sq;
    logic [mbfi_pkg::ROOT_W-1:0] trial;
    logic [mbfi_pkg::SQ_W-1:0] part;
    logic [2:0] idx;
    logic [8:0] acc;

    assign bx = position[6:0];
    assign by = position[14:8];
    assign dx = (link_in.px > bx) ? link_in.px - bx : bx - link_in.px;
    assign dy = (link_in.py > by) ? link_in.py - by : by - link_in.py;
    assign sq = (16'(dx) * 16'(dx)) + (16'(dy) * 16'(dy));

    always_comb
    begin
        rem_next  = rem_reg;
        root_next = root_reg;
        step_next = step_reg;
        hold_next = hold_reg;
        idx   = 3'(mbfi_pkg::ROOT_STEPS - 32'(step_reg));
        trial = root_reg | (8'd1 << idx);
        part  = 16'(trial) * 16'(trial);
        acc   = 9'(hold_reg.sum) + 9'(mbfi_pkg::recip(root_reg));
        if (start)
        begin
            rem_next  = sq;
            root_next = '0;
            step_next = STEP_W_ONE;
            hold_next = link_in;
        end
        else if (step_reg != '0)
        begin
            if (step_reg <= 4'(mbfi_pkg::ROOT_STEPS))
            begin
                if (part <= rem_reg)
                    root_next = trial;
                step_next = step_reg + 4'd1;
            end
            else
            begin
                step_next = '0;
                if (active)
                    hold_next.sum = acc[8] ? mbfi_pkg::FULL_SCALE : acc[7:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            step_reg <= '0;
        else
            step_reg <= step_next;
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        root_reg <= root_next;
        hold_reg <= hold_next;
    end

    assign link_out = hold_reg;
endmodule

### hw/rtl/metaball_field_intensity.sv
// Top level of the metaball field intensity block.
// One pixel is taken per request and yields one 8-bit intensity. The balls sit in a
// chain of cells, one per ball; the pixel and a running sum pass from cell to cell.
// Each cell loads the pixel, finds the floor square root of the squared distance
// one root bit per cycle, and then adds its reciprocal share, after which the next
// of the six cells takes the pixel and sum. The result is then offered from the
// last cell's sum register and held there until taken, and the block passes back
// through its idle state, where the next request is accepted. One pixel is in
// flight at a time.
module metaball_field_intensity (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // pixel_x [6:0], pixel_y [13:7], zeros
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // intensity [7:0]
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [14:0] cfg_data
);
    localparam int N = mbfi_pkg::CELLS;
    localparam int PHASE = mbfi_pkg::ROOT_STEPS + 2;

    mbfi_pkg::state_t state_reg, state_next;
    logic [mbfi_pkg::CNT_W-1:0] count_reg;
    logic [mbfi_pkg::POS_W-1:0] pos_reg [mbfi_pkg::POS_REGS];
    logic [3:0] tick_reg, tick_next;
    logic [2:0] cell_reg, cell_next;
    logic [mbfi_pkg::CNT_W-1:0] active_n;
    mbfi_pkg::link_t seed_reg;
    mbfi_pkg::link_t link [N+1];
    logic [N-1:0] start;
    logic [7:0] fin;

    assign active_n = (count_reg > 3'(N)) ? 3'(N) : count_reg;

    // Seed the chain with the accepted pixel and an empty sum.
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            seed_reg.px  <= s_axis_tdata[6:0];
            seed_reg.py  <= s_axis_tdata[13:7];
            seed_reg.sum <= '0;
        end
    end

    assign link[0] = seed_reg;

    genvar g;
    generate
        for (g = 0; g < N; g++)
        begin : g_cell
            assign start[g] = (state_reg == mbfi_pkg::ST_RUN) && (cell_reg == 3'(g))
                              && (tick_reg == '0);
            mbfi_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .start    (start[g]),
                .active   (3'(g) < active_n),
                .position (pos_reg[g]),
                .link_in  (link[g]),
                .link_out (link[g+1])
            );
        end
    endgenerate

    // The last cell holds its sum while the result waits, so take the offset off there.
    assign fin = (link[N].sum > mbfi_pkg::FLOOR_OFFSET) ?
                 link[N].sum - mbfi_pkg::FLOOR_OFFSET : '0;

    // Step the chain one cell per phase; hold the result until taken.
    always_comb
    begin
        state_next = state_reg;
        tick_next  = tick_reg;
        cell_next  = cell_reg;
        case (state_reg)
            mbfi_pkg::ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    state_next = mbfi_pkg::ST_RUN;
                    tick_next  = '0;
                    cell_next  = '0;
                end
            end
            mbfi_pkg::ST_RUN:
            begin
                if (tick_reg == 4'(PHASE - 1))
                begin
                    tick_next = '0;
                    if (cell_reg == 3'(N - 1))
                        state_next = mbfi_pkg::ST_OUT;
                    else
                        cell_next = cell_reg + 3'd1;
                end
                else
                    tick_next = tick_reg + 4'd1;
            end
            mbfi_pkg::ST_OUT:
            begin
                if (m_axis_tready)
                    state_next = mbfi_pkg::ST_IDLE;
            end
            default: state_next = mbfi_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mbfi_pkg::ST_IDLE;
            tick_reg  <= '0;
            cell_reg  <= '0;
            count_reg <= 3'd3;
            for (int i = 0; i < mbfi_pkg::POS_REGS; i++)
                pos_reg[i] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            tick_reg  <= tick_next;
            cell_reg  <= cell_next;
            if (cfg_we)
            begin
                if (cfg_index == mbfi_pkg::REG_BALL_COUNT)
                    count_reg <= cfg_data[2:0];
                else if (cfg_index <= 3'(mbfi_pkg::POS_REGS))
                    pos_reg[cfg_index - 3'd1] <= cfg_data;
            end
        end
    end

    assign s_axis_tready = (state_reg == mbfi_pkg::ST_IDLE);
    assign m_axis_tvalid = (state_reg == mbfi_pkg::ST_OUT);
    assign m_axis_tdata  = fin;
endmodule

### hw/rtl/mbfi_checker.sv
// Port-level checker for the metaball field block, with its bind.
module mbfi_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata
);
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata <= 8'd223) else $error("intensity out of range");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped");
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready) else $error("second request taken");
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready) else $error("request taken with result pending");
endmodule

bind metaball_field_intensity mbfi_checker u_mbfi_checker (
    .clk(clk), .rst_n(rst_n), .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata));

### tb/tb_metaball_field_intensity.sv
// Self-checking testbench for the metaball field intensity block.
module tb_metaball_field_intensity;
    typedef struct packed {
        logic [mbfi_pkg::COORD_W-1:0] py;
        logic [mbfi_pkg::COORD_W-1:0] px;
    } pixel_t;

    localparam logic [2:0] REG_BALL0 = 3'd1;
    localparam logic [2:0] REG_UNUSED = 3'd7;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [14:0] cfg_data;

    // Predictor copy of the registers
    logic [mbfi_pkg::CNT_W-1:0] ball_count_q;
    logic [mbfi_pkg::POS_W-1:0] ball_pos_q [mbfi_pkg::POS_REGS];

    pixel_t      pending_pixels[$];
    logic [7:0]  expected_intensity[$];
    int          send_idle_pct;
    int          recv_idle_pct;
    int          hold_off_cycles;
    bit          send_pause;
    int          mismatches;
    int          accepted;

    metaball_field_intensity dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    // Floor square root by restoring bit-pair method
    function automatic int floor_root(input int v);
        int root;
        int b;
        root = 0;
        b = 1 << 30;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= root + b)
            begin
                v = v - (root + b);
                root = (root >> 1) + b;
            end
            else
                root = root >> 1;
            b = b >> 2;
        end
        return root;
    endfunction

    // Sum ball shares with saturation, then take off the floor offset
    function automatic logic [7:0] field_intensity(input pixel_t p);
        int n;
        int sum;
        int bx;
        int by;
        int dx;
        int dy;
        int d;
        n = ball_count_q;
        if (n > mbfi_pkg::BALL_LIMIT)
            n = mbfi_pkg::BALL_LIMIT;
        if (n > mbfi_pkg::POS_REGS)
            n = mbfi_pkg::POS_REGS;
        sum = 0;
        for (int b = 0; b < n; b++)
        begin
            bx = ball_pos_q[b][6:0];
            by = ball_pos_q[b][14:8];
            dx = (p.px > bx) ? p.px - bx : bx - p.px;
            dy = (p.py > by) ? p.py - by : by - p.py;
            d = floor_root(dx * dx + dy * dy);
            sum += (d != 0) ? 255 / d : 255;
            if (sum > 255)
                sum = 255;
        end
        sum = (sum > 32) ? sum - 32 : 0;
        return 8'(sum);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    endtask

    // Write one register at idle; mirror it in the predictor
    task automatic write_reg(input logic [2:0] idx, input logic [14:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == mbfi_pkg::REG_BALL_COUNT)
            ball_count_q = val[2:0];
        else if (idx >= REG_BALL0 && idx < REG_BALL0 + mbfi_pkg::POS_REGS)
            ball_pos_q[idx - REG_BALL0] = val;
    endtask

    task automatic queue_pixel(input int x, input int y);
        pixel_t p;
        p.px = 7'(x);
        p.py = 7'(y);
        pending_pixels.push_back(p);
    endtask

    // Let all queued pixels drain, plus the pipeline latency
    task automatic wait_drained();
        while (pending_pixels.size() != 0 || s_axis_tvalid || expected_intensity.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    // Driver: present queued pixels, idling at random
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                expected_intensity.push_back(field_intensity(pixel_t'(s_axis_tdata[13:0])));
                accepted++;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (pending_pixels.size() != 0 && !send_pause
                    && $urandom_range(99) >= send_idle_pct)
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= {2'b00, pending_pixels.pop_front()};
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: check each result against the oldest expectation, stall at random
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_intensity.size() == 0)
                    report_mismatch("unexpected result", m_axis_tdata, -1);
                else if (m_axis_tdata !== expected_intensity[0])
                    report_mismatch("intensity", m_axis_tdata, expected_intensity.pop_front());
                else
                    void'(expected_intensity.pop_front());
            end
            if (hold_off_cycles > 0)
            begin
                hold_off_cycles--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial
    begin
        #50_000_000;
        $display("tb_metaball_field_intensity NOT OK");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        send_idle_pct = 38;
        recv_idle_pct = 55;
        hold_off_cycles = 0;
        send_pause = 1'b0;
        mismatches = 0;
        accepted = 0;
        ball_count_q = 3'd3;
        for (int i = 0; i < mbfi_pkg::POS_REGS; i++)
            ball_pos_q[i] = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings first: three balls stacked at the origin
        queue_pixel(0, 0);
        queue_pixel(127, 127);
        queue_pixel(1, 0);
        wait_drained();

        // Directed: balls at corners and centre, extremes of coords,
        // unused bit 7 set, unknown register index
        write_reg(mbfi_pkg::REG_BALL_COUNT, 15'd6);
        write_reg(REG_BALL0 + 3'd0, {7'd0, 1'b1, 7'd0});
        write_reg(REG_BALL0 + 3'd1, {7'd127, 1'b0, 7'd127});
        write_reg(REG_BALL0 + 3'd2, {7'd0, 1'b1, 7'd127});
        write_reg(REG_BALL0 + 3'd3, {7'd127, 1'b0, 7'd0});
        write_reg(REG_BALL0 + 3'd4, {7'd64, 1'b1, 7'd64});
        write_reg(REG_BALL0 + 3'd5, {7'd64, 1'b0, 7'd65});
        write_reg(REG_UNUSED, 15'h7fff);
        queue_pixel(0, 0);
        queue_pixel(127, 127);
        queue_pixel(0, 127);
        queue_pixel(127, 0);
        queue_pixel(64, 64);
        queue_pixel(64, 65);
        queue_pixel(85, 42);
        queue_pixel(42, 85);
        wait_drained();

        // Count above the limit acts as six; then zero and one balls
        write_reg(mbfi_pkg::REG_BALL_COUNT, 15'd7);
        queue_pixel(10, 100);
        queue_pixel(64, 64);
        wait_drained();
        write_reg(mbfi_pkg::REG_BALL_COUNT, 15'd0);
        queue_pixel(64, 64);
        queue_pixel(0, 0);
        wait_drained();
        write_reg(mbfi_pkg::REG_BALL_COUNT, 15'd1);
        queue_pixel(0, 0);
        queue_pixel(0, 3);
        queue_pixel(127, 127);
        wait_drained();

        // Random phases through the idling schedule, fresh settings each time
        for (int ph = 0; ph < 6; ph++)
        begin
            if (ph == 2)
            begin
                send_idle_pct = 55;
                recv_idle_pct = 38;
            end
            else if (ph == 4)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_reg(mbfi_pkg::REG_BALL_COUNT, 15'($urandom_range(7)));
            for (int b = 0; b < mbfi_pkg::POS_REGS; b++)
                write_reg(REG_BALL0 + 3'(b), 15'($urandom_range(32767)));
            for (int k = 0; k < 180; k++)
            begin
                // Mostly near a ball to hit large shares and saturation
                if ($urandom_range(2) == 0)
                    queue_pixel($urandom_range(127), $urandom_range(127));
                else
                begin
                    int b;
                    int x;
                    int y;
                    b = $urandom_range(mbfi_pkg::POS_REGS - 1);
                    x = ball_pos_q[b][6:0] + $urandom_range(6) - 3;
                    y = ball_pos_q[b][14:8] + $urandom_range(6) - 3;
                    queue_pixel(x < 0 ? 0 : (x > 127 ? 127 : x),
                                y < 0 ? 0 : (y > 127 ? 127 : y));
                end
                if (ph == 1 && k == 60)
                begin
                    // Long receiver hold-off while the sender keeps offering
                    while (pending_pixels.size() > 100)
                        @(posedge clk);
                    hold_off_cycles = 600;
                end
                if (ph == 3 && k == 90)
                begin
                    // Sender pauses until every result is in
                    send_pause = 1'b1;
                    while (expected_intensity.size() != 0 || s_axis_tvalid)
                        @(posedge clk);
                    send_pause = 1'b0;
                end
            end
            wait_drained();
        end

        if (mismatches == 0)
            $display("tb_metaball_field_intensity OK");
        else
            $display("tb_metaball_field_intensity NOT OK");
        $finish;
    end
endmodule
